// ----- hw/rtl/sstb_pkg.sv -----
// ----------------------------------------------------------------------------
// Seconds and sub-seconds time base: shared package
// Constants, register indexes, query codes and the divider request and response types.
// ----------------------------------------------------------------------------
`default_nettype none

package sstb_pkg;

   localparam int STAMP_WIDTH_DEF = 32;

   localparam int FREQ_W  = 32;
   localparam int TPS_W   = 10;
   localparam int SECS_W  = 32;
   localparam int USEC_W  = 20;
   localparam int PROD_W  = FREQ_W + USEC_W;
   localparam int OP_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
   localparam logic [USEC_W-1:0] USEC_MAX     = 20'd999999;

   localparam logic [TPS_W-1:0]  TPS_RESET    = 10'd100;
   localparam logic [FREQ_W-1:0] FREQ_RESET   = 32'd9375000;

   localparam logic [OP_W-1:0] OP_NONE     = 2'd0;
   localparam logic [OP_W-1:0] OP_TIME     = 2'd1;
   localparam logic [OP_W-1:0] OP_TIMEBASE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_ENABLED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUX_TPS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STAMP_FREQ    = 2'd2;

   typedef struct packed {
      logic              start;
      logic [FREQ_W-1:0] stamp;
      logic [FREQ_W-1:0] divisor;
   } sstb_div_req_type;

   typedef struct packed {
      logic              done;
      logic [USEC_W-1:0] quotient;
   } sstb_div_rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sstb_divider.sv -----
// ----------------------------------------------------------------------------
// Microsecond divider
// Scales the stamp by one million, then runs a restoring divide by the stamp
// frequency, one quotient bit per cycle over a shared subtract and compare.
// ----------------------------------------------------------------------------
`default_nettype none

module sstb_divider
   import sstb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sstb_div_req_type div_req,
   output sstb_div_rsp_type      div_rsp
);

   localparam int CNT_W = $clog2(USEC_W);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_STEP
   } div_state_type;

   div_state_type     state_ff;
   logic [FREQ_W-1:0] stamp_ff;
   logic [FREQ_W-1:0] divisor_ff;
   logic [FREQ_W-1:0] rem_ff;
   logic [USEC_W-1:0] num_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              done_ff;

   logic [PROD_W-1:0] prod;
   logic [FREQ_W:0]   trial;
   logic [FREQ_W-1:0] diff;
   logic              ge;

   assign prod  = PROD_W'(stamp_ff) * PROD_W'(USEC_PER_SEC);
   assign trial = {rem_ff, num_ff[USEC_W-1]};
   assign diff  = trial[FREQ_W-1:0] - divisor_ff;
   assign ge    = trial >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            DIV_IDLE: begin
               if (div_req.start) begin
                  stamp_ff   <= div_req.stamp;
                  divisor_ff <= div_req.divisor;
                  state_ff   <= DIV_MUL;
               end
            end
            DIV_MUL: begin
               rem_ff   <= prod[PROD_W-1:USEC_W];
               num_ff   <= prod[USEC_W-1:0];
               count_ff <= '0;
               state_ff <= DIV_STEP;
            end
            DIV_STEP: begin
               rem_ff   <= ge ? diff : trial[FREQ_W-1:0];
               num_ff   <= {num_ff[USEC_W-2:0], ge};
               count_ff <= count_ff + 1'b1;
               if (count_ff == CNT_W'(USEC_W - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= DIV_IDLE;
               end
            end
            default: state_ff <= DIV_IDLE;
         endcase
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/seconds_subseconds_time_base.sv -----
// ----------------------------------------------------------------------------
// Seconds and sub-seconds time base
// Seconds, auxiliary tick and stamp counters with time and timebase queries.
//
// Usage:
//   Each request on req_ (valid/ready) carries a stamp tick, an aux tick and
//   a query code, and yields exactly one response on rsp_ (valid/ready).
//   Ticks are applied first, then the query reads the updated counters.
//   Write registers through csr_ while no request is in flight; the block
//   does not enforce this. A request without a time query, with a saturated
//   stamp or while disabled has its response valid in the cycle after
//   acceptance. A time query runs the microsecond divider: it latches the
//   operands, multiplies by one million and takes twenty restoring divide
//   steps, then the response register is loaded; no new request is taken
//   while the divider runs, and its loop yields one quotient bit per cycle.
//   The response register is held until rsp_ready; a new request is taken
//   once that register is empty or being emptied in the same cycle.
//   Reset clears all counters, disables the timer and loads 100 aux ticks
//   per second and a stamp frequency of 9375000.
// ----------------------------------------------------------------------------
`default_nettype none

module seconds_subseconds_time_base
   import sstb_pkg::*;
#(
   parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [FREQ_W-1:0]    csr_wdata,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_stamp_tick,
   input  wire logic                 req_aux_tick,
   input  wire logic [OP_W-1:0]      req_op,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_second_pulse,
   output logic [OP_W-1:0]           rsp_read_kind,
   output logic [SECS_W-1:0]         rsp_seconds,
   output logic [USEC_W-1:0]         rsp_microsecs,
   output logic [FREQ_W-1:0]         rsp_stamp_count,
   output logic                      rsp_overrun
);

   localparam int CMP_W = (STAMP_WIDTH > FREQ_W) ? STAMP_WIDTH : FREQ_W;

   typedef enum logic {
      S_IDLE,
      S_WAIT
   } state_type;

   state_type              state_ff;
   logic                   enabled_ff;
   logic [TPS_W-1:0]       tps_ff;
   logic [FREQ_W-1:0]      freq_ff;
   logic [TPS_W-1:0]       aux_count_ff;
   logic [SECS_W-1:0]      seconds_ff;
   logic [STAMP_WIDTH-1:0] stamp_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_second_pulse_ff;
   logic [OP_W-1:0]        rsp_read_kind_ff;
   logic [SECS_W-1:0]      rsp_seconds_ff;
   logic [USEC_W-1:0]      rsp_microsecs_ff;
   logic [FREQ_W-1:0]      rsp_stamp_count_ff;
   logic                   rsp_overrun_ff;

   logic                   accept;
   logic [OP_W-1:0]        kind;
   logic [TPS_W:0]         aux_next;
   logic                   aux_step;
   logic                   roll;
   logic [STAMP_WIDTH-1:0] stamp_ticked;
   logic [STAMP_WIDTH-1:0] stamp_in;
   logic [TPS_W-1:0]       aux_count_in;
   logic [SECS_W-1:0]      seconds_in;
   logic [CMP_W-1:0]       stamp_ext;
   logic                   sat;
   logic                   is_time;
   logic                   is_base;
   logic                   need_div;

   sstb_div_req_type       div_req;
   sstb_div_rsp_type       div_rsp;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign kind = (req_op == OP_TIME || req_op == OP_TIMEBASE) ? req_op : OP_NONE;

   assign aux_next     = {1'b0, aux_count_ff} + 1'b1;
   assign aux_step     = enabled_ff && req_aux_tick;
   assign roll         = aux_step && (aux_next >= {1'b0, tps_ff});
   assign stamp_ticked = (enabled_ff && req_stamp_tick) ? stamp_ff + 1'b1 : stamp_ff;
   assign stamp_in     = roll ? '0 : stamp_ticked;
   assign aux_count_in = roll ? '0 : (aux_step ? aux_next[TPS_W-1:0] : aux_count_ff);
   assign seconds_in   = roll ? seconds_ff + 1'b1 : seconds_ff;

   assign stamp_ext = CMP_W'(stamp_in);
   assign sat       = stamp_ext >= CMP_W'(freq_ff);
   assign is_time   = enabled_ff && (kind == OP_TIME);
   assign is_base   = enabled_ff && (kind == OP_TIMEBASE);
   assign need_div  = is_time && !sat;

   assign div_req.start   = accept && need_div;
   assign div_req.stamp   = stamp_ext[FREQ_W-1:0];
   assign div_req.divisor = freq_ff;

   sstb_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enabled_ff   <= 1'b0;
         tps_ff       <= TPS_RESET;
         freq_ff      <= FREQ_RESET;
         aux_count_ff <= '0;
         seconds_ff   <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  aux_count_ff        <= aux_count_in;
                  seconds_ff          <= seconds_in;
                  stamp_ff            <= stamp_in;
                  rsp_second_pulse_ff <= roll;
                  rsp_read_kind_ff    <= kind;
                  rsp_seconds_ff      <= enabled_ff ? seconds_in : '0;
                  rsp_microsecs_ff    <= (is_time && sat) ? USEC_MAX : '0;
                  rsp_stamp_count_ff  <= is_base ? stamp_ext[FREQ_W-1:0] : '0;
                  rsp_overrun_ff      <= is_time && sat;
                  rsp_valid_ff        <= !need_div;
                  if (need_div) begin
                     state_ff <= S_WAIT;
                  end
               end else if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_WAIT: begin
               if (div_rsp.done) begin
                  rsp_microsecs_ff <= div_rsp.quotient;
                  rsp_valid_ff     <= 1'b1;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TIMER_ENABLED: begin
                  if (!enabled_ff && csr_wdata[0]) begin
                     stamp_ff <= '0;
                  end
                  enabled_ff <= csr_wdata[0];
               end
               CSR_AUX_TPS:    tps_ff  <= csr_wdata[TPS_W-1:0];
               CSR_STAMP_FREQ: freq_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_second_pulse = rsp_second_pulse_ff;
   assign rsp_read_kind    = rsp_read_kind_ff;
   assign rsp_seconds      = rsp_seconds_ff;
   assign rsp_microsecs    = rsp_microsecs_ff;
   assign rsp_stamp_count  = rsp_stamp_count_ff;
   assign rsp_overrun      = rsp_overrun_ff;

endmodule

`default_nettype wire

// ----- verif/seconds_subseconds_time_base_tb.sv -----
// ----------------------------------------------------------------------------
// Seconds and sub-seconds time base: testbench
// Drives tick and query requests through the request channel, keeps a shadow
// copy of the counters and registers to predict every response, and compares
// each response field by field. Covers the disabled state, rollover, the
// microsecond conversion with its saturation, register masking, back-pressure
// and random stalls on both channels.
// ----------------------------------------------------------------------------
module seconds_subseconds_time_base_tb
   import sstb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0]      OP_UNKNOWN = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int                   SETTLE_CYCLES = 30;

   typedef struct packed {
      logic              pulse;
      logic [OP_W-1:0]   kind;
      logic [SECS_W-1:0] secs;
      logic [USEC_W-1:0] usec;
      logic [FREQ_W-1:0] stamp;
      logic              ovr;
   } time_reading_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FREQ_W-1:0]    csr_wdata;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_stamp_tick;
   logic                 req_aux_tick;
   logic [OP_W-1:0]      req_op;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_second_pulse;
   logic [OP_W-1:0]      rsp_read_kind;
   logic [SECS_W-1:0]    rsp_seconds;
   logic [USEC_W-1:0]    rsp_microsecs;
   logic [FREQ_W-1:0]    rsp_stamp_count;
   logic                 rsp_overrun;

   logic                 shadow_enabled;
   logic [TPS_W-1:0]     shadow_tps;
   logic [FREQ_W-1:0]    shadow_freq;
   logic [TPS_W-1:0]     shadow_aux_count;
   logic [SECS_W-1:0]    shadow_seconds;
   logic [FREQ_W-1:0]    shadow_stamp;

   time_reading_type     pending_readings[$];
   int unsigned          mismatch_count = 0;
   bit                   idle_on = 1'b1;
   int unsigned          rsp_hold_len = 0;

   seconds_subseconds_time_base i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stamp_tick   (req_stamp_tick),
      .req_aux_tick     (req_aux_tick),
      .req_op           (req_op),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_second_pulse (rsp_second_pulse),
      .rsp_read_kind    (rsp_read_kind),
      .rsp_seconds      (rsp_seconds),
      .rsp_microsecs    (rsp_microsecs),
      .rsp_stamp_count  (rsp_stamp_count),
      .rsp_overrun      (rsp_overrun)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("seconds_subseconds_time_base_tb: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- shadow

   task automatic reset_shadow();
      shadow_enabled   = 1'b0;
      shadow_tps       = TPS_RESET;
      shadow_freq      = FREQ_RESET;
      shadow_aux_count = '0;
      shadow_seconds   = '0;
      shadow_stamp     = '0;
   endtask

   function automatic time_reading_type next_reading(logic stamp_tick, logic aux_tick,
                                                     logic [OP_W-1:0] op);
      time_reading_type r;
      longint unsigned  quot;
      r = '0;
      r.kind = (op == OP_TIME || op == OP_TIMEBASE) ? op : OP_NONE;
      if (shadow_enabled) begin
         if (stamp_tick)
            shadow_stamp = shadow_stamp + 1'b1;
         if (aux_tick) begin
            if ({1'b0, shadow_aux_count} + 11'd1 >= {1'b0, shadow_tps}) begin
               shadow_aux_count = '0;
               shadow_stamp     = '0;
               shadow_seconds   = shadow_seconds + 1'b1;
               r.pulse          = 1'b1;
            end else begin
               shadow_aux_count = shadow_aux_count + 1'b1;
            end
         end
         r.secs = shadow_seconds;
         if (r.kind == OP_TIME) begin
            if (shadow_freq == '0 || shadow_stamp >= shadow_freq) begin
               r.usec = USEC_MAX;
               r.ovr  = 1'b1;
            end else begin
               quot = (64'(shadow_stamp) * 64'd1000000) / 64'(shadow_freq);
               if (quot > 64'(USEC_MAX)) begin
                  r.usec = USEC_MAX;
                  r.ovr  = 1'b1;
               end else begin
                  r.usec = USEC_W'(quot);
               end
            end
         end else if (r.kind == OP_TIMEBASE) begin
            r.stamp = shadow_stamp;
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [FREQ_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_TIMER_ENABLED: begin
            if (!shadow_enabled && data[0])
               shadow_stamp = '0;
            shadow_enabled = data[0];
         end
         CSR_AUX_TPS:    shadow_tps  = data[TPS_W-1:0];
         CSR_STAMP_FREQ: shadow_freq = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_request(logic stamp_tick, logic aux_tick, logic [OP_W-1:0] op);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_stamp_tick <= stamp_tick;
      req_aux_tick   <= aux_tick;
      req_op         <= op;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_readings.push_back(next_reading(stamp_tick, aux_tick, op));
   endtask

   task automatic send_random_request(int aux_pct);
      int               pick;
      logic [OP_W-1:0]  op;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         op = OP_TIME;
      else if (pick < 70)
         op = OP_TIMEBASE;
      else if (pick < 90)
         op = OP_NONE;
      else
         op = OP_UNKNOWN;
      send_request($urandom_range(0, 99) < 70, $urandom_range(0, 99) < aux_pct, op);
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_rate(logic [TPS_W-1:0] tps, logic [FREQ_W-1:0] freq);
      csr_write(CSR_AUX_TPS, {22'($urandom), tps});
      csr_write(CSR_STAMP_FREQ, freq);
   endtask

   // ---------------------------------------------------------------- receiver

   initial begin : rsp_flow
      int burst;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_len) @(posedge clock);
            rsp_hold_len = 0;
            rsp_ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic flag_error(string msg);
      if (mismatch_count < 10)
         $display("%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v)
         flag_error($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v));
   endtask

   always @(posedge clock) begin : check_rsp
      time_reading_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            flag_error("response with no request outstanding");
         end else begin
            exp_r = pending_readings.pop_front();
            check_field("second_pulse", exp_r.pulse, rsp_second_pulse);
            check_field("read_kind", exp_r.kind, rsp_read_kind);
            check_field("seconds", exp_r.secs, rsp_seconds);
            check_field("microsecs", exp_r.usec, rsp_microsecs);
            check_field("stamp_count", exp_r.stamp, rsp_stamp_count);
            check_field("overrun", exp_r.ovr, rsp_overrun);
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_disabled();
      send_request(1'b1, 1'b1, OP_TIME);
      send_request(1'b1, 1'b1, OP_TIMEBASE);
      send_request(1'b0, 1'b0, OP_NONE);
      send_request(1'b1, 1'b0, OP_UNKNOWN);
      wait_for_idle();
   endtask

   task automatic test_conversion_and_rollover();
      csr_write(CSR_TIMER_ENABLED, {31'($urandom), 1'b1});
      set_rate(10'd3, 32'd4);
      csr_write(CSR_UNUSED, $urandom);
      send_request(1'b1, 1'b0, OP_TIMEBASE);
      send_request(1'b1, 1'b0, OP_TIME);
      send_request(1'b1, 1'b0, OP_TIME);
      send_request(1'b1, 1'b0, OP_TIME);
      send_request(1'b0, 1'b1, OP_UNKNOWN);
      send_request(1'b1, 1'b1, OP_TIMEBASE);
      send_request(1'b1, 1'b1, OP_TIME);
      wait_for_idle();
   endtask

   task automatic test_zero_settings();
      csr_write(CSR_STAMP_FREQ, 32'd0);
      send_request(1'b1, 1'b0, OP_TIME);
      wait_for_idle();
      csr_write(CSR_AUX_TPS, 32'd0);
      send_request(1'b0, 1'b1, OP_TIMEBASE);
      wait_for_idle();
   endtask

   task automatic test_lowered_tps();
      csr_write(CSR_AUX_TPS, 32'd5);
      repeat (3) send_request(1'b0, 1'b1, OP_NONE);
      wait_for_idle();
      csr_write(CSR_AUX_TPS, 32'd2);
      send_request(1'b0, 1'b1, OP_NONE);
      wait_for_idle();
   endtask

   task automatic test_extreme_settings();
      set_rate(10'd1000, 32'hFFFF_FFFF);
      send_request(1'b1, 1'b0, OP_TIME);
      send_request(1'b1, 1'b1, OP_TIMEBASE);
      wait_for_idle();
   endtask

   task automatic test_enable_toggle();
      csr_write(CSR_TIMER_ENABLED, 32'd0);
      send_request(1'b1, 1'b1, OP_TIME);
      wait_for_idle();
      csr_write(CSR_TIMER_ENABLED, 32'd1);
      csr_write(CSR_TIMER_ENABLED, 32'hFFFF_FFFF);
      send_request(1'b0, 1'b0, OP_TIMEBASE);
      wait_for_idle();
   endtask

   task automatic run_random_phase(int n_items, logic [TPS_W-1:0] tps,
                                   logic [FREQ_W-1:0] freq, int aux_pct);
      set_rate(tps, freq);
      for (int i = 0; i < n_items; i++) begin
         send_random_request(aux_pct);
         // hold the sender until the block has drained
         if (i == n_items / 2 && $urandom_range(0, 1) == 1)
            wait_for_idle();
      end
      wait_for_idle();
   endtask

   task automatic test_random_mix();
      run_random_phase(250, 10'd4, 32'd30, 25);
      run_random_phase(250, 10'd1000, 32'd150, 10);
      run_random_phase(200, 10'd1, $urandom, 20);
      run_random_phase(200, 10'd2, 32'd0, 30);
      csr_write(CSR_TIMER_ENABLED, 32'd0);
      run_random_phase(100, 10'd3, 32'd10, 30);
      csr_write(CSR_TIMER_ENABLED, 32'd1);
      run_random_phase(250, 10'($urandom_range(1, 12)), 32'($urandom_range(1, 64)), 20);
      run_random_phase(200, 10'd0, FREQ_RESET, 15);
   endtask

   task automatic test_backpressure();
      set_rate(10'd4, 32'd20);
      idle_on = 1'b0;
      rsp_hold_len = 300;
      repeat (40) send_random_request(25);
      wait_for_idle();
      idle_on = 1'b1;
   endtask

   task automatic test_full_rate();
      idle_on = 1'b0;
      run_random_phase(350, 10'd6, 32'd40, 25);
   endtask

   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_TIMER_ENABLED;
      csr_wdata        <= '0;
      req_valid        <= 1'b0;
      req_stamp_tick   <= 1'b0;
      req_aux_tick     <= 1'b0;
      req_op           <= OP_NONE;
      reset_shadow();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled();
      test_conversion_and_rollover();
      test_zero_settings();
      test_lowered_tps();
      test_extreme_settings();
      test_enable_toggle();
      test_random_mix();
      test_backpressure();
      test_full_rate();

      if (pending_readings.size() != 0)
         flag_error($sformatf("%0d responses never arrived", pending_readings.size()));
      if (mismatch_count == 0)
         $display("seconds_subseconds_time_base_tb: done, clean");
      else
         $display("seconds_subseconds_time_base_tb: done, errors");
      $finish;
   end

endmodule

// ----- seconds_subseconds_time_base.f -----
hw/rtl/sstb_pkg.sv
hw/rtl/sstb_divider.sv
hw/rtl/seconds_subseconds_time_base.sv
verif/seconds_subseconds_time_base_tb.sv
